>>> rtl/stw_pkg.sv
// Shared types and constants for the stale telemetry watchdog.
`timescale 1ns / 1ps

package stw_pkg;

  localparam int unsigned FrameCountW = 9;
  localparam int unsigned ChangeCountW = 16;
  localparam int unsigned InDataW = 112;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned CfgAddrW = 3;

  localparam logic [7:0] CheckIntervalReset = 8'd20;
  localparam logic [15:0] WindowSecondsReset = 16'd900;

  // Register index, taken from paddr[2].
  localparam logic RegCheckInterval = 1'b0;
  localparam logic RegWindowSeconds = 1'b1;

  typedef struct packed {
    logic signed [15:0] pack_voltage;
    logic signed [15:0] pack_current;
    logic signed [15:0] max_cell_voltage;
    logic signed [7:0]  max_cell_temp;
    logic signed [7:0]  state_of_charge;
    logic [15:0]        time_left;
    logic [31:0]        now_seconds;
  } frame_t;

  typedef struct packed {
    logic [7:0]  check_interval;
    logic [15:0] window_seconds;
  } cfg_t;

  typedef struct packed {
    logic alarm;
    logic frame_valid;
  } result_t;

endpackage

>>> rtl/stw_cfg.sv
// APB register file holding the check interval and the window length.
`timescale 1ns / 1ps

module stw_cfg
  import stw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cfg_t                cfg
);

  logic wr_en;
  logic reg_sel;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_interval <= CheckIntervalReset;
      cfg.window_seconds <= WindowSecondsReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegCheckInterval: cfg.check_interval <= pwdata[7:0];
        RegWindowSeconds: cfg.window_seconds <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegCheckInterval: prdata = {24'd0, cfg.check_interval};
      RegWindowSeconds: prdata = {16'd0, cfg.window_seconds};
      default:          prdata = 32'd0;
    endcase
  end

  // Low address bits are not decoded.
  logic unused_addr;
  assign unused_addr = ^paddr[1:0];

endmodule

>>> rtl/stw_core.sv
// Watchdog state and the combinational check of one registered frame.
`timescale 1ns / 1ps

module stw_core
  import stw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    fire,
  input  frame_t  frame,
  output result_t result
);

  logic                    started;
  logic [31:0]             window_start;
  logic [FrameCountW-1:0]  frame_count;
  logic [ChangeCountW-1:0] change_count;
  frame_t                  snap;

  logic                    started_next;
  logic [31:0]             window_start_next;
  logic [FrameCountW-1:0]  frame_count_next;
  logic [ChangeCountW-1:0] change_count_next;
  logic                    snap_load;

  logic                    valid;
  logic                    check;
  logic                    differs;
  logic                    reached;
  logic                    alarm;
  logic [31:0]             ws_eff;
  logic [31:0]             elapsed;
  logic [FrameCountW-1:0]  fc_inc;
  logic [ChangeCountW-1:0] cc_upd;

  function automatic logic positive16(logic signed [15:0] x);
    return (x != 16'sd0) && !x[15];
  endfunction

  function automatic logic positive8(logic signed [7:0] x);
    return (x != 8'sd0) && !x[7];
  endfunction

  always_comb begin
    valid = positive16(frame.pack_voltage) && positive16(frame.pack_current) &&
            positive16(frame.max_cell_voltage) && positive8(frame.max_cell_temp) &&
            positive8(frame.state_of_charge);

    // Before the first valid frame the frame itself is the snapshot.
    differs = started &&
              (frame.pack_voltage != snap.pack_voltage ||
               frame.pack_current != snap.pack_current ||
               frame.max_cell_voltage != snap.max_cell_voltage ||
               frame.max_cell_temp != snap.max_cell_temp ||
               frame.state_of_charge != snap.state_of_charge ||
               frame.time_left != snap.time_left);
    ws_eff = started ? window_start : frame.now_seconds;

    fc_inc = (frame_count == '1) ? frame_count : frame_count + 1'b1;
    check = frame_count > {1'b0, cfg.check_interval};

    cc_upd = change_count;
    if (differs && change_count != '1) cc_upd = change_count + 1'b1;

    // Time going backward counts as zero elapsed.
    elapsed = frame.now_seconds - ws_eff;
    if (frame.now_seconds < ws_eff) reached = (cfg.window_seconds == 16'd0);
    else                            reached = elapsed >= {16'd0, cfg.window_seconds};

    alarm = valid && check && reached && (cc_upd == '0);

    started_next = started;
    window_start_next = window_start;
    frame_count_next = frame_count;
    change_count_next = change_count;
    snap_load = 1'b0;
    if (valid) begin
      started_next = 1'b1;
      snap_load = !started || (check && differs);
      window_start_next = ws_eff;
      frame_count_next = fc_inc;
      if (check) begin
        change_count_next = cc_upd;
        if (reached) begin
          window_start_next = frame.now_seconds;
          if (cc_upd != '0) change_count_next = '0;
        end
        if (!alarm) frame_count_next = '0;
      end
    end

    result.alarm = alarm;
    result.frame_valid = valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      window_start <= '0;
      frame_count <= '0;
      change_count <= '0;
      snap <= '0;
    end else if (fire) begin
      started <= started_next;
      window_start <= window_start_next;
      frame_count <= frame_count_next;
      change_count <= change_count_next;
      if (snap_load) snap <= frame;
    end
  end

endmodule

>>> rtl/stale_telemetry_watchdog.sv
// Top level: stream input register, watchdog core, result register, APB port.
`timescale 1ns / 1ps

// Takes one battery status frame per item and returns one result per item:
// frame_valid tells whether voltage, current, cell voltage, temperature and
// state of charge were all positive, and alarm goes high when an observation
// window of window_seconds closed with no telemetry change seen. Frames are
// compared with a stored snapshot only once the valid-frame counter exceeds
// check_interval. The block accepts one item per clock while the result side
// does not stall: an item waits in the input register, where the whole check
// and state update runs combinationally, and its result is loaded into the
// output register when the input stage advances. A stall on the result side
// holds both stages. The output register lets a new item be accepted while a
// result is still waiting to be taken.
module stale_telemetry_watchdog
  import stw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // pack_voltage[15:0], pack_current[31:16], max_cell_voltage[47:32],
  // max_cell_temp[55:48], state_of_charge[63:56], time_left[79:64],
  // now_seconds[111:80]
  input  logic [InDataW-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // alarm[0], frame_valid[1], zero fill[7:2]
  output logic [OutDataW-1:0] m_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t    cfg;
  frame_t  in_frame;
  frame_t  s1_frame;
  logic    s1_valid;
  logic    s1_fire;
  logic    s_fire;
  result_t result;
  result_t out_result;

  stw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_frame.pack_voltage     = s_tdata[15:0];
  assign in_frame.pack_current     = s_tdata[31:16];
  assign in_frame.max_cell_voltage = s_tdata[47:32];
  assign in_frame.max_cell_temp    = s_tdata[55:48];
  assign in_frame.state_of_charge  = s_tdata[63:56];
  assign in_frame.time_left        = s_tdata[79:64];
  assign in_frame.now_seconds      = s_tdata[111:80];

  // Advance the input stage whenever the result register is free or draining.
  assign s1_fire  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_fire;
  assign s_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) s1_frame <= in_frame;
  end

  stw_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (s1_fire),
    .frame  (s1_frame),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) out_result <= result;
  end

  assign m_tdata = {6'd0, out_result.frame_valid, out_result.alarm};

  a_alarm_needs_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[0] || m_tdata[1]))
    else $error("alarm raised on an invalid frame");

  a_result_follows_fire: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> m_tvalid && (m_tdata[0] == $past(result.alarm)))
    else $error("processed item did not reach the result register");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("item accepted while both stages are stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s1_valid)
    else $error("stages not empty after reset");

endmodule
